[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ssfs_pkg.sv]
// Shared types, constants and codes for the sprite sheet frame stepper
package ssfs_pkg;

  localparam int DEF_MAX_DIVISIONS = 16;
  localparam int DEF_TIME_BITS     = 24;

  // field and register widths
  localparam int DIVREG_W    = 5;
  localparam int PERIOD_W    = 24;
  localparam int DT_W        = 16;
  localparam int FRAME_IDX_W = 8;
  localparam int CELL_W      = 4;
  localparam int UV_W        = 17;   // Q1.16, also the quotient width of the divider
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISIONS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_PLAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DESTROY = 3'd4;

  // register reset values
  localparam logic [DIVREG_W-1:0] RST_DIVISIONS    = 5'd4;
  localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD = 24'd62500;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_STEP,
    ST_LAUNCH,
    ST_WAIT,
    ST_OUT
  } seq_state_e;

  // divider jobs in issue order
  typedef enum logic [2:0] {
    JOB_ROW,
    JOB_U0,
    JOB_V0,
    JOB_U1,
    JOB_V1
  } job_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/ssfs_div.sv]
// Shared radix-2 divider: one compare and subtract per cycle, fixed quotient width
module ssfs_div import ssfs_pkg::*; #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output div_stat_t        stat_o,
  output logic [UV_W-1:0]  quo_o,
  output logic [DVD_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(UV_W + 1);

  logic [DVD_W-1:0] rem_q;
  logic [DVD_W-1:0] dsh_q;
  logic [UV_W-1:0]  quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             fits;
  logic [DVD_W-1:0] diff;

  assign fits = rem_q >= dsh_q;
  assign diff = rem_q - dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CNT_W'(UV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bit per step, divisor walks down from its top position
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= DVD_W'(divisor_i) << (UV_W - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= diff;
      end
      quo_q <= {quo_q[UV_W-2:0], fits};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;
  assign rem_o       = rem_q;

endmodule

[hdl/ssfs_seq.sv]
// Sequencer: play state, accumulator update, divider jobs and result register
module ssfs_seq import ssfs_pkg::*; #(
  parameter int DIV_W   = 5,
  parameter int RC_W    = 4,
  parameter int FRAME_W = 8,
  parameter int ACC_W   = 25,
  parameter int PER_W   = 24,
  parameter int DVD_W   = 23,
  parameter int DVS_W   = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   cmd_i,
  input  logic [DT_W-1:0]        delta_time_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   advanced_o,
  output logic [FRAME_IDX_W-1:0] frame_index_o,
  output logic [CELL_W-1:0]      cell_row_o,
  output logic [CELL_W-1:0]      cell_col_o,
  output logic [UV_W-1:0]        uv_start_u_o,
  output logic [UV_W-1:0]        uv_start_v_o,
  output logic [UV_W-1:0]        uv_end_u_o,
  output logic [UV_W-1:0]        uv_end_v_o,
  output logic                   playing_o,
  output logic                   delete_request_o,
  input  logic [DIV_W-1:0]       div_eff_i,
  input  logic [PER_W-1:0]       period_i,
  input  logic                   loop_enable_i,
  input  logic                   reverse_play_i,
  input  logic                   auto_destroy_i,
  output logic                   div_start_o,
  output logic [DVD_W-1:0]       div_dividend_o,
  output logic [DVS_W-1:0]       div_divisor_o,
  input  div_stat_t              div_stat_i,
  input  logic [UV_W-1:0]        div_quo_i,
  input  logic [DVD_W-1:0]       div_rem_i
);

  localparam int SUM_W = ((ACC_W > DT_W) ? ACC_W : DT_W) + 1;
  localparam int TOT_W = 2 * DIV_W;

  seq_state_e state_q, state_d;
  job_e       job_q, job_d;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               play_q, play_d;
  logic               del_q, del_d;
  logic               out_valid_q, out_valid_d;

  logic               cmd_q, cmd_d;
  logic [DT_W-1:0]    dt_q, dt_d;
  logic               adv_q, adv_d;
  logic [FRAME_W-1:0] fout_q, fout_d;
  logic [RC_W-1:0]    row_q, row_d;
  logic [RC_W-1:0]    col_q, col_d;
  logic [UV_W-1:0]    uvsu_q, uvsu_d;
  logic [UV_W-1:0]    uvsv_q, uvsv_d;
  logic [UV_W-1:0]    uveu_q, uveu_d;
  logic [UV_W-1:0]    uvev_q, uvev_d;
  logic               out_load;

  logic                   out_adv_q;
  logic [FRAME_IDX_W-1:0] out_frame_q;
  logic [CELL_W-1:0]      out_row_q;
  logic [CELL_W-1:0]      out_col_q;
  logic [UV_W-1:0]        out_uvsu_q;
  logic [UV_W-1:0]        out_uvsv_q;
  logic [UV_W-1:0]        out_uveu_q;
  logic [UV_W-1:0]        out_uvev_q;
  logic                   out_play_q;
  logic                   out_del_q;

  logic [TOT_W-1:0]   total;
  logic [FRAME_W-1:0] last_frame;
  logic [FRAME_W-1:0] f_eff;
  logic [SUM_W-1:0]   sum;
  logic [ACC_W-1:0]   acc_sat;
  logic [ACC_W-1:0]   per_ext;
  logic               reach;
  logic [RC_W:0]      uv_n;
  logic [DVD_W-1:0]   uv_dvd;

  // frame count and clamp of a stale frame to the last cell
  assign total      = TOT_W'(div_eff_i) * TOT_W'(div_eff_i);
  assign last_frame = FRAME_W'(total - TOT_W'(1));
  assign f_eff      = (TOT_W'(frame_q) >= total) ? last_frame : frame_q;

  // accumulator add with saturation, then period check
  assign sum     = SUM_W'(acc_q) + SUM_W'(dt_q);
  assign acc_sat = (|sum[SUM_W-1:ACC_W]) ? '1 : sum[ACC_W-1:0];
  assign per_ext = ACC_W'(period_i);
  assign reach   = acc_q >= per_ext;

  // uv(n) = (n * 2^17 + d) / (2d), rounds n/d in Q1.16 to nearest
  always_comb begin
    case (job_q)
      JOB_U0:  uv_n = (RC_W+1)'(col_q);
      JOB_V0:  uv_n = (RC_W+1)'(row_q);
      JOB_U1:  uv_n = (RC_W+1)'(col_q) + (RC_W+1)'(1);
      JOB_V1:  uv_n = (RC_W+1)'(row_q) + (RC_W+1)'(1);
      default: uv_n = '0;
    endcase
  end

  assign uv_dvd = (DVD_W'(uv_n) << UV_W) + DVD_W'(div_eff_i);

  always_comb begin
    if (job_q == JOB_ROW) begin
      div_dividend_o = DVD_W'(f_eff);
      div_divisor_o  = DVS_W'(div_eff_i);
    end else begin
      div_dividend_o = uv_dvd;
      div_divisor_o  = {div_eff_i, 1'b0};
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    acc_d       = acc_q;
    frame_d     = frame_q;
    play_d      = play_q;
    del_d       = del_q;
    cmd_d       = cmd_q;
    dt_d        = dt_q;
    adv_d       = adv_q;
    fout_d      = fout_q;
    row_d       = row_q;
    col_d       = col_q;
    uvsu_d      = uvsu_q;
    uvsv_d      = uvsv_q;
    uveu_d      = uveu_q;
    uvev_d      = uvev_q;
    div_start_o = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          dt_d    = delta_time_i;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        adv_d   = 1'b0;
        job_d   = JOB_ROW;
        state_d = ST_LAUNCH;
        if (cmd_q == CMD_START) begin
          frame_d = reverse_play_i ? last_frame : '0;
          acc_d   = '0;
          play_d  = 1'b1;
          del_d   = 1'b0;
        end else if (play_q) begin
          acc_d   = acc_sat;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        state_d = ST_LAUNCH;
        if (reach) begin
          acc_d = acc_q - per_ext;
          adv_d = 1'b1;
          if (reverse_play_i) begin
            if (f_eff == '0) begin
              if (loop_enable_i) begin
                frame_d = last_frame;
              end else begin
                frame_d = '0;
                play_d  = 1'b0;
                del_d   = del_q || auto_destroy_i;
              end
            end else begin
              frame_d = f_eff - FRAME_W'(1);
            end
          end else begin
            if (f_eff == last_frame) begin
              if (loop_enable_i) begin
                frame_d = '0;
              end else begin
                frame_d = last_frame;
                play_d  = 1'b0;
                del_d   = del_q || auto_destroy_i;
              end
            end else begin
              frame_d = f_eff + FRAME_W'(1);
            end
          end
        end
      end
      ST_LAUNCH: begin
        if (!div_stat_i.busy) begin
          div_start_o = 1'b1;
          state_d     = ST_WAIT;
          if (job_q == JOB_ROW) begin
            fout_d = f_eff;
          end
        end
      end
      ST_WAIT: begin
        if (div_stat_i.done) begin
          state_d = ST_LAUNCH;
          unique case (job_q)
            JOB_ROW: begin
              row_d = RC_W'(div_quo_i);
              col_d = RC_W'(div_rem_i);
              job_d = JOB_U0;
            end
            JOB_U0: begin
              uvsu_d = div_quo_i;
              job_d  = JOB_V0;
            end
            JOB_V0: begin
              uvsv_d = div_quo_i;
              job_d  = JOB_U1;
            end
            JOB_U1: begin
              uveu_d = div_quo_i;
              job_d  = JOB_V1;
            end
            JOB_V1: begin
              uvev_d  = div_quo_i;
              state_d = ST_OUT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_ROW;
      acc_q       <= '0;
      frame_q     <= '0;
      play_q      <= 1'b0;
      del_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      acc_q       <= acc_d;
      frame_q     <= frame_d;
      play_q      <= play_d;
      del_q       <= del_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    dt_q   <= dt_d;
    adv_q  <= adv_d;
    fout_q <= fout_d;
    row_q  <= row_d;
    col_q  <= col_d;
    uvsu_q <= uvsu_d;
    uvsv_q <= uvsv_d;
    uveu_q <= uveu_d;
    uvev_q <= uvev_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_adv_q   <= adv_q;
      out_frame_q <= FRAME_IDX_W'(fout_q);
      out_row_q   <= CELL_W'(row_q);
      out_col_q   <= CELL_W'(col_q);
      out_uvsu_q  <= uvsu_q;
      out_uvsv_q  <= uvsv_q;
      out_uveu_q  <= uveu_q;
      out_uvev_q  <= uvev_q;
      out_play_q  <= play_q;
      out_del_q   <= del_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign advanced_o       = out_adv_q;
  assign frame_index_o    = out_frame_q;
  assign cell_row_o       = out_row_q;
  assign cell_col_o       = out_col_q;
  assign uv_start_u_o     = out_uvsu_q;
  assign uv_start_v_o     = out_uvsv_q;
  assign uv_end_u_o       = out_uveu_q;
  assign uv_end_v_o       = out_uvev_q;
  assign playing_o        = out_play_q;
  assign delete_request_o = out_del_q;

endmodule

[hdl/sprite_sheet_frame_stepper.sv]
// Sprite sheet frame stepper: registers, effective settings and the two units
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer:
//   cmd_i selects a start (restart play from the first cell, or the last in
//   reverse) or a time tick; delta_time_i gives the elapsed microseconds.
//   Output channel (out_valid_o / out_stall_i) gives one result per item:
//   frame, row, column, the four cell UVs in Q1.16 and the play flags.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   no item is in flight; unknown indexes are ignored.
// Sequence
//   The shared divider runs five jobs per item (row and column, then four
//   UVs), 17 quotient steps each, each launched in ST_LAUNCH and collected
//   in ST_WAIT. A tick while playing first passes the period check state
//   (ST_STEP). in_stall_o is high from the transfer until the result is in
//   the output register, so a new item is taken only after the last one
//   has reached it.
// Reset and back-pressure
//   Reset clears frame, accumulator and flags and loads the register
//   defaults. A stalled result holds in the output register; the next item
//   is still taken and computed, and waits for the register to free up.
module sprite_sheet_frame_stepper import ssfs_pkg::*; #(
  parameter int MAX_DIVISIONS = DEF_MAX_DIVISIONS,
  parameter int TIME_BITS     = DEF_TIME_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   cmd_i,
  input  logic [DT_W-1:0]        delta_time_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   advanced_o,
  output logic [FRAME_IDX_W-1:0] frame_index_o,
  output logic [CELL_W-1:0]      cell_row_o,
  output logic [CELL_W-1:0]      cell_col_o,
  output logic [UV_W-1:0]        uv_start_u_o,
  output logic [UV_W-1:0]        uv_start_v_o,
  output logic [UV_W-1:0]        uv_end_u_o,
  output logic [UV_W-1:0]        uv_end_v_o,
  output logic                   playing_o,
  output logic                   delete_request_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  // widths that follow from the sheet size and the time base
  localparam int DIV_W   = $clog2(MAX_DIVISIONS + 1);
  localparam int RC_W    = (MAX_DIVISIONS > 1) ? $clog2(MAX_DIVISIONS) : 1;
  localparam int FRAME_W = (MAX_DIVISIONS > 1) ? $clog2(MAX_DIVISIONS * MAX_DIVISIONS) : 1;
  localparam int ACC_W   = TIME_BITS + 1;
  localparam int PER_W   = (TIME_BITS < PERIOD_W) ? TIME_BITS : PERIOD_W;
  localparam int DVS_W   = DIV_W + 1;           // holds 2 * divisions
  localparam int DVD_W   = DIV_W + UV_W + 1;    // holds n * 2^17 + divisions
  localparam int CMP_W   = (DIV_W > DIVREG_W) ? DIV_W : DIVREG_W;

  logic [DIVREG_W-1:0] divisions_q;
  logic [PERIOD_W-1:0] frame_period_q;
  logic                loop_q;
  logic                reverse_q;
  logic                auto_q;

  logic [CMP_W-1:0] div_raw;
  logic [DIV_W-1:0] div_eff;
  logic [PER_W-1:0] period;

  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  div_stat_t        div_stat;
  logic [UV_W-1:0]  div_quo;
  logic [DVD_W-1:0] div_rem;

  // register file, to be written only while idle: the user is bound, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisions_q    <= RST_DIVISIONS;
      frame_period_q <= RST_FRAME_PERIOD;
      loop_q         <= 1'b0;
      reverse_q      <= 1'b0;
      auto_q         <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIVISIONS:    divisions_q    <= cfg_wdata_i[DIVREG_W-1:0];
        CFG_FRAME_PERIOD: frame_period_q <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_LOOP_ENABLE:  loop_q         <= cfg_wdata_i[0];
        CFG_REVERSE_PLAY: reverse_q      <= cfg_wdata_i[0];
        CFG_AUTO_DESTROY: auto_q         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // zero divisions acts as one, oversize saturates to the sheet limit
  assign div_raw = CMP_W'(divisions_q);
  always_comb begin
    if (div_raw == '0) begin
      div_eff = DIV_W'(1);
    end else if (div_raw > CMP_W'(MAX_DIVISIONS)) begin
      div_eff = DIV_W'(MAX_DIVISIONS);
    end else begin
      div_eff = DIV_W'(div_raw);
    end
  end

  // only the low PER_W bits of the period count (TIME_BITS, capped at PERIOD_W)
  assign period = frame_period_q[PER_W-1:0];

  ssfs_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  ssfs_seq #(
    .DIV_W   (DIV_W),
    .RC_W    (RC_W),
    .FRAME_W (FRAME_W),
    .ACC_W   (ACC_W),
    .PER_W   (PER_W),
    .DVD_W   (DVD_W),
    .DVS_W   (DVS_W)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .delta_time_i     (delta_time_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .advanced_o       (advanced_o),
    .frame_index_o    (frame_index_o),
    .cell_row_o       (cell_row_o),
    .cell_col_o       (cell_col_o),
    .uv_start_u_o     (uv_start_u_o),
    .uv_start_v_o     (uv_start_v_o),
    .uv_end_u_o       (uv_end_u_o),
    .uv_end_v_o       (uv_end_v_o),
    .playing_o        (playing_o),
    .delete_request_o (delete_request_o),
    .div_eff_i        (div_eff),
    .period_i         (period),
    .loop_enable_i    (loop_q),
    .reverse_play_i   (reverse_q),
    .auto_destroy_i   (auto_q),
    .div_start_o      (div_start),
    .div_dividend_o   (div_dividend),
    .div_divisor_o    (div_divisor),
    .div_stat_i       (div_stat),
    .div_quo_i        (div_quo),
    .div_rem_i        (div_rem)
  );

endmodule

[hdl/ssfs_checker.sv]
// Port-level checker for the sprite sheet frame stepper, bound to the top level
`include "assert_macros.svh"

module ssfs_checker import ssfs_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [UV_W-1:0] uv_start_u_o,
  input logic [UV_W-1:0] uv_start_v_o,
  input logic [UV_W-1:0] uv_end_u_o,
  input logic [UV_W-1:0] uv_end_v_o,
  input logic            playing_o,
  input logic            delete_request_o
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // one item at a time: busy right after an input transfer
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken while an item is in work")

  // cell edges are ordered
  `ASSERT_HOLDS(a_uv_order, clk_i, rst_ni, !out_valid_o || (uv_start_u_o <= uv_end_u_o && uv_start_v_o <= uv_end_v_o), "cell UV start beyond end")

  // delete is only requested once play has stopped
  `ASSERT_HOLDS(a_del_stopped, clk_i, rst_ni, !out_valid_o || !delete_request_o || !playing_o, "delete request while playing")

endmodule

bind sprite_sheet_frame_stepper ssfs_checker u_ssfs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .uv_start_u_o     (uv_start_u_o),
  .uv_start_v_o     (uv_start_v_o),
  .uv_end_u_o       (uv_end_u_o),
  .uv_end_v_o       (uv_end_v_o),
  .playing_o        (playing_o),
  .delete_request_o (delete_request_o)
);
